// ===== rtl/grdc_pkg.sv =====
// ----------------------------------------------------------------------------
// grdc_pkg
// Shared types and constants of the grid ray caster.
// ----------------------------------------------------------------------------
package grdc_pkg;

    localparam int POS_W   = 24;
    localparam int DIR_W   = 18;
    localparam int CFG_W   = 24;
    localparam int IDX_W   = 3;
    localparam int DIST_W  = 32;
    localparam int CELL_W  = 6;
    localparam int VAL_W   = 8;
    localparam int COL_W   = 10;
    localparam int CAM_W   = 28;
    localparam int PROD_W  = DIR_W + CAM_W;
    localparam int RD_W    = 31;
    localparam int NUM_W   = 33;
    localparam int DCNT_W  = 6;
    localparam int IN_W    = 32;
    localparam int OUT_W   = 80;
    localparam int CMUL_W  = 39;
    localparam int CAM_SHIFT = 22;
    localparam int CPROD_W = COL_W + CMUL_W;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CAST  = 1'b1;

    localparam logic [IDX_W-1:0] REG_POS_X   = 3'd0;
    localparam logic [IDX_W-1:0] REG_POS_Y   = 3'd1;
    localparam logic [IDX_W-1:0] REG_DIR_X   = 3'd2;
    localparam logic [IDX_W-1:0] REG_DIR_Y   = 3'd3;
    localparam logic [IDX_W-1:0] REG_PLANE_X = 3'd4;
    localparam logic [IDX_W-1:0] REG_PLANE_Y = 3'd5;

    localparam logic [1:0] SIDE_NORTH = 2'd0;
    localparam logic [1:0] SIDE_SOUTH = 2'd1;
    localparam logic [1:0] SIDE_WEST  = 2'd2;
    localparam logic [1:0] SIDE_EAST  = 2'd3;

    localparam logic [NUM_W-1:0] RECIP_NUM  = 33'h1_0000_0000;
    localparam logic [DIST_W-1:0] DIST_SAT  = 32'hFFFF_FFFF;
    localparam logic [DCNT_W-1:0] DIV_STEPS = 6'd33;

    typedef enum logic [11:0] {
        ST_CLEAR = 12'b0000_0000_0001,
        ST_IDLE  = 12'b0000_0000_0010,
        ST_CAM   = 12'b0000_0000_0100,
        ST_MULX  = 12'b0000_0000_1000,
        ST_MULY  = 12'b0000_0001_0000,
        ST_RDY   = 12'b0000_0010_0000,
        ST_RECX  = 12'b0000_0100_0000,
        ST_RECY  = 12'b0000_1000_0000,
        ST_DISTX = 12'b0001_0000_0000,
        ST_DISTY = 12'b0010_0000_0000,
        ST_STEP  = 12'b0100_0000_0000,
        ST_CHECK = 12'b1000_0000_0000
    } state_t;

endpackage

// ===== rtl/grdc_ram.sv =====
// ----------------------------------------------------------------------------
// grdc_ram
// Simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module grdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/grid_ray_dda_caster.sv =====
// ----------------------------------------------------------------------------
// grid_ray_dda_caster
// DDA ray caster over a square cell map held in on-chip RAM.
//
// channel  dir  payload
// s_*      in   tuser command; tdata column, cell_x, cell_y, cell_value
// m_*      out  tdata hit_x, hit_y, side, side_dist_x, side_dist_y, no_hit
// cfg_*    in   register index and data, one write per cycle
//
// A cast first computes the camera value (reciprocal multiply) in ST_CAM,
// the ray direction in ST_MULX, ST_MULY and ST_RDY, two bit-serial
// reciprocals in ST_RECX and ST_RECY, then the start distances in ST_DISTX
// and ST_DISTY. Each crossed cell then passes through ST_STEP and ST_CHECK
// for the map RAM read; the cast ends in ST_STEP when the ray leaves the
// map or hits the step limit. After reset the map RAM is cleared to zero
// with s_tready low. A finished result waits in the output register while
// the next item is taken; a stalled result holds the cast in its last state.
// ----------------------------------------------------------------------------
module grid_ray_dda_caster
    import grdc_pkg::*;
#(
    parameter int SCREEN_WIDTH = 640,
    parameter int MAP_SIDE     = 64,
    parameter int MAX_STEPS    = 128
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // column, cell_x, cell_y, cell_value, pad
    input  logic             s_tuser,   // command
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // hit_x, hit_y, side, side_dist_x,
                                        // side_dist_y, no_hit, pad
    input  logic             cfg_write,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int DEPTH = MAP_SIDE * MAP_SIDE;
    localparam int CW    = $clog2(DEPTH);
    localparam int MXW   = 10;
    localparam int NW    = $clog2(MAX_STEPS + 1);
    localparam logic [CMUL_W-1:0] CAM_MUL =
        CMUL_W'(((64'd1 << (CAM_SHIFT + 17)) + 64'(SCREEN_WIDTH) - 64'd1)
                / 64'(SCREEN_WIDTH));

    state_t                    state_reg, state_next;
    logic [CW-1:0]             clr_cnt_reg, clr_cnt_next;
    logic [POS_W-1:0]          pos_x_reg, pos_y_reg;
    logic signed [DIR_W-1:0]   dir_x_reg, dir_y_reg, plane_x_reg, plane_y_reg;
    logic signed [CAM_W-1:0]   cam_reg, cam_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [RD_W-1:0]    rdx_reg, rdx_next, rdy_reg, rdy_next;
    logic [DIST_W-1:0]         ddx_reg, ddx_next, ddy_reg, ddy_next;
    logic [DIST_W-1:0]         sdx_reg, sdx_next, sdy_reg, sdy_next;
    logic signed [MXW-1:0]     mx_reg, mx_next, my_reg, my_next;
    logic [1:0]                side_reg, side_next;
    logic [NW-1:0]             n_reg, n_next;
    logic [NUM_W-1:0]          num_reg, num_next;
    logic [RD_W-1:0]           rem_reg, rem_next, den_reg, den_next;
    logic [DCNT_W-1:0]         dcnt_reg, dcnt_next;
    logic                      out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]          out_data_reg, out_data_next;

    logic                      ram_we;
    logic [CW-1:0]             ram_waddr, ram_raddr;
    logic [VAL_W-1:0]          ram_wdata, ram_rdata;

    logic [COL_W-1:0]          in_column;
    logic [CELL_W-1:0]         in_cell_x, in_cell_y;
    logic [VAL_W-1:0]          in_value;
    logic                      in_acc;

    logic [RD_W:0]             div_r;
    logic                      div_ge;
    logic [RD_W-1:0]           div_rem;
    logic [NUM_W-1:0]          div_quo;
    logic                      div_last;
    logic [DIST_W-1:0]         div_sat;
    logic [CPROD_W-1:0]        cam_prod;

    logic [RD_W-1:0]           mag_x, mag_y;
    logic signed [RD_W-1:0]    ray_sum;
    logic [16:0]               part;
    logic [48:0]               dist_prod;
    logic [DIST_W-1:0]         dist_sat;
    logic                      step_x;
    logic [DIST_W:0]           add_sum;
    logic [DIST_W-1:0]         add_sat;
    logic signed [MXW-1:0]     nmx, nmy;
    logic                      off_map;

    assign in_column = s_tdata[9:0];
    assign in_cell_x = s_tdata[15:10];
    assign in_cell_y = s_tdata[21:16];
    assign in_value  = s_tdata[29:22];

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign cam_prod = CPROD_W'(num_reg[COL_W-1:0]) * CPROD_W'(CAM_MUL);

    always_comb
    begin
        div_r    = {rem_reg, num_reg[NUM_W-1]};
        div_ge   = div_r >= {1'b0, den_reg};
        div_rem  = div_ge ? RD_W'(div_r - {1'b0, den_reg}) : div_r[RD_W-1:0];
        div_quo  = {num_reg[NUM_W-2:0], div_ge};
        div_last = (dcnt_reg == DCNT_W'(1));
        div_sat  = div_quo[NUM_W-1] ? DIST_SAT : div_quo[DIST_W-1:0];
    end

    assign mag_x   = rdx_reg[RD_W-1] ? RD_W'(-rdx_reg) : rdx_reg;
    assign mag_y   = rdy_reg[RD_W-1] ? RD_W'(-rdy_reg) : rdy_reg;
    assign ray_sum = RD_W'($signed(state_reg == ST_MULY ? dir_x_reg : dir_y_reg))
                   + RD_W'($signed(prod_reg[PROD_W-1:16]));

    always_comb
    begin
        if (state_reg == ST_DISTX)
        begin
            part = rdx_reg[RD_W-1] ? {1'b0, pos_x_reg[15:0]}
                                   : 17'h10000 - {1'b0, pos_x_reg[15:0]};
        end
        else
        begin
            part = rdy_reg[RD_W-1] ? {1'b0, pos_y_reg[15:0]}
                                   : 17'h10000 - {1'b0, pos_y_reg[15:0]};
        end
        dist_prod = 49'(part) * 49'(state_reg == ST_DISTX ? ddx_reg : ddy_reg);
        dist_sat  = (dist_prod[48] != 1'b0) ? DIST_SAT : dist_prod[47:16];
    end

    always_comb
    begin
        step_x  = sdx_reg < sdy_reg;
        add_sum = step_x ? ({1'b0, sdx_reg} + {1'b0, ddx_reg})
                         : ({1'b0, sdy_reg} + {1'b0, ddy_reg});
        add_sat = add_sum[DIST_W] ? DIST_SAT : add_sum[DIST_W-1:0];
        nmx     = mx_reg;
        nmy     = my_reg;
        if (step_x)
        begin
            nmx = rdx_reg[RD_W-1] ? mx_reg - MXW'(1) : mx_reg + MXW'(1);
        end
        else
        begin
            nmy = rdy_reg[RD_W-1] ? my_reg - MXW'(1) : my_reg + MXW'(1);
        end
        off_map = nmx[MXW-1] || nmy[MXW-1]
               || (nmx >= $signed(MXW'(MAP_SIDE))) || (nmy >= $signed(MXW'(MAP_SIDE)));
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        cam_next       = cam_reg;
        prod_next      = prod_reg;
        rdx_next       = rdx_reg;
        rdy_next       = rdy_reg;
        ddx_next       = ddx_reg;
        ddy_next       = ddy_reg;
        sdx_next       = sdx_reg;
        sdy_next       = sdy_reg;
        mx_next        = mx_reg;
        my_next        = my_reg;
        side_next      = side_reg;
        n_next         = n_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        dcnt_next      = dcnt_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = CW'(in_cell_x) * CW'(MAP_SIDE) + CW'(in_cell_y);
        ram_wdata      = in_value;
        ram_raddr      = CW'(nmx[MXW-2:0]) * CW'(MAP_SIDE) + CW'(nmy[MXW-2:0]);

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + CW'(1);
                if (clr_cnt_reg == CW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (s_tuser == CMD_WRITE)
                    begin
                        ram_we = (int'(in_cell_x) < MAP_SIDE) && (int'(in_cell_y) < MAP_SIDE);
                    end
                    else
                    begin
                        num_next   = NUM_W'(in_column);
                        state_next = ST_CAM;
                    end
                end
            end
            ST_CAM:
            begin
                cam_next   = $signed(CAM_W'(cam_prod[CPROD_W-1:CAM_SHIFT]))
                           - CAM_W'(65536);
                state_next = ST_MULX;
            end
            ST_MULX:
            begin
                prod_next  = PROD_W'(plane_x_reg) * PROD_W'(cam_reg);
                state_next = ST_MULY;
            end
            ST_MULY:
            begin
                rdx_next   = ray_sum;
                prod_next  = PROD_W'(plane_y_reg) * PROD_W'(cam_reg);
                state_next = ST_RDY;
            end
            ST_RDY:
            begin
                rdy_next   = ray_sum;
                num_next   = RECIP_NUM;
                rem_next   = '0;
                den_next   = mag_x;
                dcnt_next  = DIV_STEPS;
                state_next = ST_RECX;
            end
            ST_RECX:
            begin
                num_next  = div_quo;
                rem_next  = div_rem;
                dcnt_next = dcnt_reg - DCNT_W'(1);
                if (div_last)
                begin
                    ddx_next   = div_sat;
                    num_next   = RECIP_NUM;
                    rem_next   = '0;
                    den_next   = mag_y;
                    dcnt_next  = DIV_STEPS;
                    state_next = ST_RECY;
                end
            end
            ST_RECY:
            begin
                num_next  = div_quo;
                rem_next  = div_rem;
                dcnt_next = dcnt_reg - DCNT_W'(1);
                if (div_last)
                begin
                    ddy_next   = div_sat;
                    state_next = ST_DISTX;
                end
            end
            ST_DISTX:
            begin
                sdx_next   = dist_sat;
                state_next = ST_DISTY;
            end
            ST_DISTY:
            begin
                sdy_next   = dist_sat;
                mx_next    = MXW'(pos_x_reg[POS_W-1:16]);
                my_next    = MXW'(pos_y_reg[POS_W-1:16]);
                n_next     = '0;
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                if (n_reg == NW'(MAX_STEPS) || off_map)
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_next = 1'b1;
                        out_data_next  = {1'b0, 1'b1,
                                          (n_reg != NW'(MAX_STEPS) && !step_x) ? add_sat : sdy_reg,
                                          (n_reg != NW'(MAX_STEPS) && step_x) ? add_sat : sdx_reg,
                                          2'd0, 6'd0, 6'd0};
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    n_next = n_reg + NW'(1);
                    mx_next = nmx;
                    my_next = nmy;
                    if (step_x)
                    begin
                        sdx_next  = add_sat;
                        side_next = rdx_reg[RD_W-1] ? SIDE_SOUTH : SIDE_NORTH;
                    end
                    else
                    begin
                        sdy_next  = add_sat;
                        side_next = rdy_reg[RD_W-1] ? SIDE_EAST : SIDE_WEST;
                    end
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                ram_raddr = CW'(mx_reg[MXW-2:0]) * CW'(MAP_SIDE) + CW'(my_reg[MXW-2:0]);
                if (ram_rdata == '0)
                begin
                    state_next = ST_STEP;
                end
                else if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {1'b0, 1'b0, sdy_reg, sdx_reg, side_reg,
                                      CELL_W'(my_reg), CELL_W'(mx_reg)};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            pos_x_reg     <= 24'h800000;
            pos_y_reg     <= 24'h800000;
            dir_x_reg     <= -18'sd65536;
            dir_y_reg     <= '0;
            plane_x_reg   <= '0;
            plane_y_reg   <= 18'sd43253;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_POS_X:   pos_x_reg   <= cfg_data;
                    REG_POS_Y:   pos_y_reg   <= cfg_data;
                    REG_DIR_X:   dir_x_reg   <= cfg_data[DIR_W-1:0];
                    REG_DIR_Y:   dir_y_reg   <= cfg_data[DIR_W-1:0];
                    REG_PLANE_X: plane_x_reg <= cfg_data[DIR_W-1:0];
                    REG_PLANE_Y: plane_y_reg <= cfg_data[DIR_W-1:0];
                    default:     ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cam_reg      <= cam_next;
        prod_reg     <= prod_next;
        rdx_reg      <= rdx_next;
        rdy_reg      <= rdy_next;
        ddx_reg      <= ddx_next;
        ddy_reg      <= ddy_next;
        sdx_reg      <= sdx_next;
        sdy_reg      <= sdy_next;
        mx_reg       <= mx_next;
        my_reg       <= my_next;
        side_reg     <= side_next;
        n_reg        <= n_next;
        num_reg      <= num_next;
        rem_reg      <= rem_next;
        den_reg      <= den_next;
        dcnt_reg     <= dcnt_next;
        out_data_reg <= out_data_next;
    end

    grdc_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

// ===== rtl/grdc_checker.sv =====
// ----------------------------------------------------------------------------
// grdc_checker
// Port-level checks of the grid ray caster, bound to the top level.
// ----------------------------------------------------------------------------
module grdc_checker
    import grdc_pkg::*;
#(
    parameter int MAP_SIDE = 64
) (
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             s_tuser,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item dropped or changed while stalled");

    a_nohit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[78] |-> m_tdata[13:0] == 14'd0)
        else $error("no-hit item carries a hit cell or side");

    a_hit_in_map: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[78] |-> int'(m_tdata[5:0]) < MAP_SIDE
                                  && int'(m_tdata[11:6]) < MAP_SIDE)
        else $error("hit cell outside the map");

    a_cast_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == CMD_CAST |=> !s_tready)
        else $error("new item taken while a cast is running");

endmodule

bind grid_ray_dda_caster grdc_checker #(
    .MAP_SIDE (MAP_SIDE)
) u_grdc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
